/* sv/oidft_pkg.sv */
// Package for the OFDM inverse-transform modulator.
// Holds item modes, the back-end state type and shared widths.
`default_nettype none
package oidft_pkg;
	localparam int unsigned VAL_W = 16;
	localparam int unsigned ACC_W = 40;

	typedef enum logic [1:0] {
		MODE_COEFF  = 2'd0,
		MODE_SYMBOL = 2'd1,
		MODE_SAMPLE = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MAC,
		BK_NORM,
		BK_SQRT,
		BK_DIV,
		BK_OUT
	} back_state_t;
endpackage
`default_nettype wire

/* sv/oidft_if.sv */
// Valid/ready channel interfaces for the modulator.
// Depends on nothing.
`default_nettype none
interface oidft_in_if;
	logic              valid;
	logic              ready;
	logic        [1:0] mode;
	logic        [5:0] carrier;
	logic        [9:0] sample_pos;
	logic signed [15:0] value_re;
	logic signed [15:0] value_im;
	modport source (output valid, mode, carrier, sample_pos, value_re, value_im,
		input ready);
	modport sink (input valid, mode, carrier, sample_pos, value_re, value_im,
		output ready);
endinterface

interface oidft_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] out_re;
	logic signed [15:0] out_im;
	logic               last;
	modport source (output valid, out_re, out_im, last, input ready);
	modport sink (input valid, out_re, out_im, last, output ready);
endinterface
`default_nettype wire

/* sv/ofdm_idft_prefix_unit_clip.sv */
// OFDM modulator with cyclic prefix and unit-magnitude output.
// Channel in_ch carries beats of mode, carrier, sample_pos, value_re/im:
// mode 0 writes one inverse-transform coefficient, mode 1 one carrier
// symbol, mode 2 requests the next time sample; mode 3 is dropped.
// Channel out_ch returns one beat per mode 2 request: out_re/out_im in
// Q1.14 with unit magnitude, and last on the final sample of the
// prefix-plus-symbol period. The prefix (symbol tail) comes first.
// Each sample beat is computed after its request beat by one complex MAC per
// carrier from the coefficient RAM port, up to 30 normalization shifts,
// 32 square-root steps and 33 division steps, all on one shared
// sequencer; a zero sum skips the square root and division. Requests are
// handled one after another.
// A two-beat request queue holds mode 2 beats; table and symbol
// writes wait until no sample is queued or being computed. If out_ch
// stalls, the finished sample stays in the output register and the back
// end computes the next one, then holds it until the register is free.
// Reset clears the sample position and all handshake state; the RAMs are
// not cleared and must be written before use.
// Depends on oidft_pkg, oidft_if, oidft_ram, oidft_front and oidft_back.
`default_nettype none
module ofdm_idft_prefix_unit_clip
	import oidft_pkg::*;
#(
	parameter int unsigned NUM_CARRIERS = 14,
	parameter int unsigned SYMBOL_LEN = 128,
	parameter int unsigned PREFIX_LEN = 32
) (
	input  wire          clk,
	input  wire          arst_n,
	oidft_in_if.sink     in_ch,
	oidft_out_if.source  out_ch
);
	localparam int unsigned KW = $clog2(SYMBOL_LEN);
	localparam int unsigned CW = (NUM_CARRIERS > 1) ? $clog2(NUM_CARRIERS) : 1;
	localparam int unsigned TD = NUM_CARRIERS * SYMBOL_LEN;
	localparam int unsigned TW = $clog2(TD);

	logic          cf_we, sy_we, req_valid, req_ready, req_last;
	logic [TW-1:0] cf_waddr, cf_raddr;
	logic [CW-1:0] sy_waddr, sy_raddr;
	logic [31:0]   wdata, cf_rdata, sy_rdata;
	logic [KW-1:0] req_k;

	oidft_front #(.NUM_CARRIERS(NUM_CARRIERS), .SYMBOL_LEN(SYMBOL_LEN),
		.PREFIX_LEN(PREFIX_LEN)) u_front (
		.clk, .arst_n, .in_ch, .cf_we, .cf_waddr, .sy_we, .sy_waddr, .wdata,
		.req_valid, .req_ready, .req_k, .req_last);

	oidft_ram #(.WIDTH(32), .DEPTH(TD)) u_coeff (
		.clk, .we(cf_we), .waddr(cf_waddr), .wdata, .raddr(cf_raddr), .rdata(cf_rdata));

	oidft_ram #(.WIDTH(32), .DEPTH(NUM_CARRIERS)) u_sym (
		.clk, .we(sy_we), .waddr(sy_waddr), .wdata, .raddr(sy_raddr), .rdata(sy_rdata));

	oidft_back #(.NUM_CARRIERS(NUM_CARRIERS), .SYMBOL_LEN(SYMBOL_LEN)) u_back (
		.clk, .arst_n, .req_valid, .req_ready, .req_k, .req_last, .cf_raddr, .cf_rdata,
		.sy_raddr, .sy_rdata, .out_ch);
endmodule
`default_nettype wire

/* sv/oidft_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
`default_nettype none
module oidft_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [AW-1:0]             waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [AW-1:0]             raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* sv/oidft_front.sv */
// Front part: accepts items, performs table and symbol writes, and queues
// sample requests with their table index and last flag. Depends on oidft_pkg and oidft_if.
`default_nettype none
module oidft_front
	import oidft_pkg::*;
#(
	parameter int unsigned NUM_CARRIERS = 14,
	parameter int unsigned SYMBOL_LEN = 128,
	parameter int unsigned PREFIX_LEN = 32,
	localparam int unsigned KW = $clog2(SYMBOL_LEN),
	localparam int unsigned CW = (NUM_CARRIERS > 1) ? $clog2(NUM_CARRIERS) : 1,
	localparam int unsigned TW = $clog2(NUM_CARRIERS * SYMBOL_LEN)
) (
	input  wire            clk,
	input  wire            arst_n,
	oidft_in_if.sink       in_ch,
	output logic           cf_we,
	output logic [TW-1:0]  cf_waddr,
	output logic           sy_we,
	output logic [CW-1:0]  sy_waddr,
	output logic [31:0]    wdata,
	output logic           req_valid,
	input  wire            req_ready,
	output logic [KW-1:0]  req_k,
	output logic           req_last
);
	localparam int unsigned PERIOD = PREFIX_LEN + SYMBOL_LEN;
	localparam int unsigned PW = $clog2(PERIOD);
	localparam int unsigned KOFS = (SYMBOL_LEN - (PREFIX_LEN % SYMBOL_LEN)) % SYMBOL_LEN;

	logic [PW-1:0] pos_q;
	logic [KW-1:0] k_q;
	logic [KW-1:0] k;
	logic          is_last;
	// Two-entry request queue.
	logic [KW:0]   qd_q [2];
	logic [1:0]    cnt_q;
	logic          acc, push, is_wr;

	assign is_wr = (mode_t'(in_ch.mode) == MODE_COEFF) || (mode_t'(in_ch.mode) == MODE_SYMBOL);
	// Table and symbol writes wait until no sample is queued or being computed.
	assign in_ch.ready = (cnt_q != 2'd2) && (!is_wr || (cnt_q == 2'd0 && req_ready));
	assign acc = in_ch.valid && in_ch.ready;
	assign push = acc && (mode_t'(in_ch.mode) == MODE_SAMPLE);

	assign is_last = (pos_q == PW'(PERIOD - 1));
	// The table index runs alongside the position, starting in the symbol tail.
	assign k = k_q;

	assign wdata = {in_ch.value_re, in_ch.value_im};
	assign cf_we = acc && (mode_t'(in_ch.mode) == MODE_COEFF)
		&& (in_ch.carrier < 7'(NUM_CARRIERS)) && (in_ch.sample_pos < 11'(SYMBOL_LEN));
	assign cf_waddr = TW'(in_ch.carrier * SYMBOL_LEN + in_ch.sample_pos);
	assign sy_we = acc && (mode_t'(in_ch.mode) == MODE_SYMBOL)
		&& (in_ch.carrier < 7'(NUM_CARRIERS));
	assign sy_waddr = CW'(in_ch.carrier);

	assign req_valid = (cnt_q != 2'd0);
	assign req_k = qd_q[0][KW:1];
	assign req_last = qd_q[0][0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			k_q <= KW'(KOFS);
			cnt_q <= '0;
		end else begin
			if (push) begin
				pos_q <= is_last ? '0 : pos_q + 1'b1;
				k_q <= is_last ? KW'(KOFS)
					: ((k_q == KW'(SYMBOL_LEN - 1)) ? '0 : k_q + 1'b1);
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, req_valid && req_ready};
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			if (push && cnt_q == 2'd1) qd_q[0] <= {k, is_last};
			else qd_q[0] <= qd_q[1];
		end else if (push) begin
			if (cnt_q == 2'd0) qd_q[0] <= {k, is_last};
			else qd_q[1] <= {k, is_last};
		end
	end
endmodule
`default_nettype wire

/* sv/oidft_back.sv */
// Back part: per-carrier complex MAC, normalization shift, bit-serial
// square root and division, output register. Depends on oidft_pkg and oidft_if.
`default_nettype none
module oidft_back
	import oidft_pkg::*;
#(
	parameter int unsigned NUM_CARRIERS = 14,
	parameter int unsigned SYMBOL_LEN = 128,
	localparam int unsigned KW = $clog2(SYMBOL_LEN),
	localparam int unsigned CW = (NUM_CARRIERS > 1) ? $clog2(NUM_CARRIERS) : 1,
	localparam int unsigned TW = $clog2(NUM_CARRIERS * SYMBOL_LEN)
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_ready,
	input  wire [KW-1:0]   req_k,
	input  wire            req_last,
	output logic [TW-1:0]  cf_raddr,
	input  wire [31:0]     cf_rdata,
	output logic [CW-1:0]  sy_raddr,
	input  wire [31:0]     sy_rdata,
	oidft_out_if.source    out_ch
);
	back_state_t st_q, st_d;
	logic [KW-1:0] k_q;
	logic          last_q;
	logic [CW:0]   c_q;       // carrier issue counter
	logic          rd_v_s1;   // RAM read data valid
	logic signed [ACC_W-1:0] re_q, im_q;
	logic signed [32:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic          p_v_s2;
	logic          neg_re_q, neg_im_q, zero_q;
	logic [31:0]   a_q, b_q;
	logic [63:0]   rem_q, bit_q, root_q;
	logic [6:0]    it_q;
	logic [47:0]   num_a_q, num_b_q;
	logic [32:0]   qa_q, qb_q, dv;
	logic signed [15:0] ore_q, oim_q;
	logic          olast_q, ovalid_q;
	logic [ACC_W-1:0] mag_re, mag_im, mx;
	logic [31:0]   mx32;
	logic [63:0]   sa, sb;

	assign req_ready = (st_q == BK_IDLE);
	assign cf_raddr = TW'(c_q * SYMBOL_LEN + k_q);
	assign sy_raddr = CW'(c_q);

	always_comb begin
		mag_re = re_q[ACC_W-1] ? ACC_W'(-re_q) : ACC_W'(re_q);
		mag_im = im_q[ACC_W-1] ? ACC_W'(-im_q) : ACC_W'(im_q);
		mx32 = (a_q > b_q) ? a_q : b_q;
		mx = (mag_re > mag_im) ? mag_re : mag_im;
		sa = {32'd0, a_q};
		sb = {32'd0, b_q};
		dv = {root_q[31:0], 1'b0};
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE: if (req_valid) st_d = BK_MAC;
			BK_MAC:  if (c_q == (CW+1)'(NUM_CARRIERS) && !rd_v_s1 && !p_v_s2) st_d = BK_NORM;
			BK_NORM: if (zero_q || (mx32 < 32'h8000_0000 && mx32 >= 32'h4000_0000))
				st_d = zero_q ? BK_OUT : BK_SQRT;
			BK_SQRT: if (it_q == 7'd31) st_d = BK_DIV;
			BK_DIV:  if (it_q == 7'd32) st_d = BK_OUT;
			BK_OUT:  if (!ovalid_q || out_ch.ready) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			ovalid_q <= 1'b0;
			rd_v_s1 <= 1'b0;
			p_v_s2 <= 1'b0;
			c_q <= '0;
			it_q <= '0;
		end else begin
			st_q <= st_d;
			if (ovalid_q && out_ch.ready) ovalid_q <= 1'b0;
			rd_v_s1 <= (st_q == BK_MAC) && (c_q != (CW+1)'(NUM_CARRIERS));
			p_v_s2 <= rd_v_s1;
			if (st_q == BK_IDLE) c_q <= '0;
			else if (st_q == BK_MAC && c_q != (CW+1)'(NUM_CARRIERS)) c_q <= c_q + 1'b1;
			if (st_q == BK_SQRT || st_q == BK_DIV) it_q <= (st_d != st_q) ? '0 : it_q + 1'b1;
			else it_q <= '0;
			if (st_q == BK_OUT && st_d == BK_IDLE) ovalid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			BK_IDLE: begin
				k_q <= req_k;
				last_q <= req_last;
				re_q <= '0;
				im_q <= '0;
			end
			BK_MAC: begin
				p_rr_s2 <= 33'($signed(sy_rdata[31:16]) * $signed(cf_rdata[31:16]));
				p_ii_s2 <= 33'($signed(sy_rdata[15:0]) * $signed(cf_rdata[15:0]));
				p_ri_s2 <= 33'($signed(sy_rdata[31:16]) * $signed(cf_rdata[15:0]));
				p_ir_s2 <= 33'($signed(sy_rdata[15:0]) * $signed(cf_rdata[31:16]));
				if (p_v_s2) begin
					re_q <= re_q + ACC_W'(p_rr_s2) - ACC_W'(p_ii_s2);
					im_q <= im_q + ACC_W'(p_ri_s2) + ACC_W'(p_ir_s2);
				end else if (!rd_v_s1 && c_q == (CW+1)'(NUM_CARRIERS)) begin
					neg_re_q <= re_q[ACC_W-1];
					neg_im_q <= im_q[ACC_W-1];
					zero_q <= (re_q == '0) && (im_q == '0);
					// Coarse step: bring the larger magnitude below 2^31.
					if (mx >= ACC_W'(64'h8000_0000)) begin
						a_q <= 32'(mag_re >> (ACC_W - 32));
						b_q <= 32'(mag_im >> (ACC_W - 32));
						re_q <= $signed(mag_re);
						im_q <= $signed(mag_im);
					end else begin
						a_q <= mag_re[31:0];
						b_q <= mag_im[31:0];
						re_q <= '0;
						im_q <= '0;
					end
				end
			end
			BK_NORM: begin
				// re_q and im_q hold the wide magnitudes when the coarse step truncated.
				if (!zero_q) begin
					if ((re_q != '0 || im_q != '0) && mx32 < 32'h4000_0000) begin
						// Too far down: regain one bit from the wide value.
						re_q <= re_q <<< 1;
						im_q <= im_q <<< 1;
						a_q <= 32'(ACC_W'(re_q <<< 1) >> (ACC_W - 32));
						b_q <= 32'(ACC_W'(im_q <<< 1) >> (ACC_W - 32));
					end else if (mx32 >= 32'h8000_0000) begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
					end else if (mx32 < 32'h4000_0000) begin
						a_q <= a_q << 1;
						b_q <= b_q << 1;
					end
				end
				rem_q <= sa * sa + sb * sb;
				bit_q <= 64'h4000_0000_0000_0000;
				root_q <= '0;
			end
			BK_SQRT: begin
				if (rem_q >= root_q + bit_q) begin
					rem_q <= rem_q - (root_q + bit_q);
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
				num_a_q <= {1'b0, a_q, 15'd0};
				num_b_q <= {1'b0, b_q, 15'd0};
				qa_q <= '0;
				qb_q <= '0;
			end
			BK_DIV: begin
				if (it_q == 7'd0) begin
					num_a_q <= num_a_q + 48'(root_q[31:0]);
					num_b_q <= num_b_q + 48'(root_q[31:0]);
				end else begin
					// Restoring division, quotient bits 15 down to 0.
					if (it_q <= 7'd16) begin
						if (num_a_q >= (48'(dv) << (16 - it_q))) begin
							num_a_q <= num_a_q - (48'(dv) << (16 - it_q));
							qa_q <= qa_q | (33'd1 << (16 - it_q));
						end
						if (num_b_q >= (48'(dv) << (16 - it_q))) begin
							num_b_q <= num_b_q - (48'(dv) << (16 - it_q));
							qb_q <= qb_q | (33'd1 << (16 - it_q));
						end
					end
				end
			end
			BK_OUT: begin
				if (st_d == BK_IDLE) begin
					ore_q <= zero_q ? 16'sd16384 : (neg_re_q ? -$signed(qa_q[15:0]) : $signed(qa_q[15:0]));
					oim_q <= zero_q ? 16'sd0 : (neg_im_q ? -$signed(qb_q[15:0]) : $signed(qb_q[15:0]));
					olast_q <= last_q;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.out_re = ore_q;
	assign out_ch.out_im = oim_q;
	assign out_ch.last = olast_q;
endmodule
`default_nettype wire

/* test/oidft_checker.sv */
// Checker for the OFDM modulator: watches both channels, predicts each sample
// from the table and symbol writes it sees, and compares the returned beats.
// Depends on oidft_pkg and oidft_if.
`default_nettype none
module oidft_checker
	import oidft_pkg::*;
#(
	parameter int unsigned NUM_CARRIERS = 14,
	parameter int unsigned SYMBOL_LEN = 128,
	parameter int unsigned PREFIX_LEN = 32
) (
	input  wire   clk,
	input  wire   arst_n,
	oidft_in_if   in_ch,
	oidft_out_if  out_ch,
	output int    fail_cnt,
	output int    pending
);
	localparam int unsigned PERIOD = PREFIX_LEN + SYMBOL_LEN;

	typedef struct {
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic               last;
	} sample_t;

	logic signed [15:0] coeff_re [NUM_CARRIERS*SYMBOL_LEN];
	logic signed [15:0] coeff_im [NUM_CARRIERS*SYMBOL_LEN];
	logic signed [15:0] sym_re [NUM_CARRIERS];
	logic signed [15:0] sym_im [NUM_CARRIERS];
	int unsigned        sample_idx;
	sample_t            expected_q [$];

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Scales the complex sum to unit magnitude in Q1.14.
	function automatic sample_t unit_sample(longint sre, longint sim, logic last);
		sample_t s;
		longint unsigned a, b, mx, m, qa, qb;
		s.last = last;
		if (sre == 0 && sim == 0) begin
			s.re = 16'sd16384;
			s.im = 16'sd0;
			return s;
		end
		a = (sre < 0) ? longint'(-sre) : longint'(sre);
		b = (sim < 0) ? longint'(-sim) : longint'(sim);
		mx = (a > b) ? a : b;
		while (mx >= (64'd1 << 31)) begin a >>= 1; b >>= 1; mx >>= 1; end
		while (mx < (64'd1 << 30)) begin a <<= 1; b <<= 1; mx <<= 1; end
		m = int_sqrt(a * a + b * b);
		qa = ((a << 15) + m) / (2 * m);
		qb = ((b << 15) + m) / (2 * m);
		s.re = (sre < 0) ? 16'(-longint'(qa)) : 16'(qa);
		s.im = (sim < 0) ? 16'(-longint'(qb)) : 16'(qb);
		return s;
	endfunction

	function automatic sample_t next_sample(int unsigned p);
		longint      acc_re, acc_im, sr, si, wr, wi;
		int unsigned k;
		acc_re = 0;
		acc_im = 0;
		k = (p + SYMBOL_LEN - (PREFIX_LEN % SYMBOL_LEN)) % SYMBOL_LEN;
		for (int c = 0; c < NUM_CARRIERS; c++) begin
			sr = sym_re[c];
			si = sym_im[c];
			wr = coeff_re[c*SYMBOL_LEN + k];
			wi = coeff_im[c*SYMBOL_LEN + k];
			acc_re += sr * wr - si * wi;
			acc_im += sr * wi + si * wr;
		end
		return unit_sample(acc_re, acc_im, p == PERIOD - 1);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sample_t want;
		if (!arst_n) begin
			sample_idx = 0;
			fail_cnt = 0;
			pending = 0;
		end else begin
			// The returned beat always belongs to an earlier request, so pop first.
			if (out_ch.valid && out_ch.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected sample re=%0d im=%0d last=%0b", $time,
						out_ch.out_re, out_ch.out_im, out_ch.last);
					fail_cnt++;
				end else begin
					want = expected_q.pop_front();
					if (want.re !== out_ch.out_re || want.im !== out_ch.out_im ||
							want.last !== out_ch.last) begin
						$display("%0t: sample mismatch: expected re=%0d im=%0d last=%0b, got re=%0d im=%0d last=%0b",
							$time, want.re, want.im, want.last,
							out_ch.out_re, out_ch.out_im, out_ch.last);
						fail_cnt++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				case (mode_t'(in_ch.mode))
					MODE_COEFF: begin
						if (in_ch.carrier < NUM_CARRIERS && in_ch.sample_pos < SYMBOL_LEN) begin
							coeff_re[in_ch.carrier*SYMBOL_LEN + in_ch.sample_pos] = in_ch.value_re;
							coeff_im[in_ch.carrier*SYMBOL_LEN + in_ch.sample_pos] = in_ch.value_im;
						end
					end
					MODE_SYMBOL: begin
						if (in_ch.carrier < NUM_CARRIERS) begin
							sym_re[in_ch.carrier] = in_ch.value_re;
							sym_im[in_ch.carrier] = in_ch.value_im;
						end
					end
					MODE_SAMPLE: begin
						expected_q.push_back(next_sample(sample_idx));
						sample_idx = (sample_idx == PERIOD - 1) ? 0 : sample_idx + 1;
					end
					default: ;
				endcase
			end
			pending = expected_q.size();
		end
	end
endmodule
`default_nettype wire

/* test/testbench.sv */
// Top of the modulator testbench: drives table, symbol and sample beats with
// random gaps, stalls the output side, and reports the verdict.
// Depends on oidft_pkg, oidft_if, ofdm_idft_prefix_unit_clip and oidft_checker.
`default_nettype none
module testbench;
	import oidft_pkg::*;

	localparam int unsigned NC = 14;
	localparam int unsigned SL = 128;
	localparam int unsigned PL = 32;
	localparam int unsigned PERIOD = PL + SL;
	localparam int RANDOM_ITEMS = 1800;
	localparam int IDLE_LIMIT = 4000;

	logic clk;
	logic arst_n;
	int   fail_cnt;
	int   pending;
	int   idle_cycles;
	int   beats_sent;
	bit   no_gaps;

	// Which store entries have been written, so that no sample reads an unwritten one.
	bit          coeff_known [NC*SL];
	bit          sym_known [NC];
	int unsigned sample_idx;

	oidft_in_if  in_ch ();
	oidft_out_if out_ch ();

	ofdm_idft_prefix_unit_clip #(.NUM_CARRIERS(NC), .SYMBOL_LEN(SL), .PREFIX_LEN(PL)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	oidft_checker #(.NUM_CARRIERS(NC), .SYMBOL_LEN(SL), .PREFIX_LEN(PL)) i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.fail_cnt (fail_cnt),
		.pending  (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'($signed($urandom_range(0, 510)) - 255);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_beat(mode_t mode, logic [5:0] carrier, logic [9:0] spos,
			logic [15:0] vre, logic [15:0] vim);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= mode;
		in_ch.carrier <= carrier;
		in_ch.sample_pos <= spos;
		in_ch.value_re <= vre;
		in_ch.value_im <= vim;
		do @(posedge clk); while (!in_ch.ready);
		beats_sent++;
		if (mode == MODE_COEFF && carrier < NC && spos < SL) coeff_known[carrier*SL + spos] = 1'b1;
		if (mode == MODE_SYMBOL && carrier < NC) sym_known[carrier] = 1'b1;
		if (mode == MODE_SAMPLE) sample_idx = (sample_idx == PERIOD - 1) ? 0 : sample_idx + 1;
	endtask

	// Fills whatever the next sample would read, then asks for the sample.
	task automatic request_sample();
		int unsigned k;
		k = (sample_idx + SL - (PL % SL)) % SL;
		for (int c = 0; c < NC; c++) begin
			if (!sym_known[c]) send_beat(MODE_SYMBOL, 6'(c), 10'($urandom), rand_value(), rand_value());
			if (!coeff_known[c*SL + k])
				send_beat(MODE_COEFF, 6'(c), 10'(k), rand_value(), rand_value());
		end
		send_beat(MODE_SAMPLE, 6'($urandom), 10'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) request_sample();
		else if (r < 65)
			send_beat(MODE_COEFF, 6'($urandom_range(0, NC-1)), 10'($urandom_range(0, SL-1)),
				rand_value(), rand_value());
		else if (r < 78)
			send_beat(MODE_SYMBOL, 6'($urandom_range(0, NC-1)), 10'($urandom),
				rand_value(), rand_value());
		else if (r < 84)
			send_beat(MODE_COEFF, 6'($urandom_range(NC, 63)), 10'($urandom),
				rand_value(), rand_value());
		else if (r < 90)
			send_beat(MODE_COEFF, 6'($urandom_range(0, 63)), 10'($urandom_range(SL, 1023)),
				rand_value(), rand_value());
		else if (r < 95)
			send_beat(MODE_SYMBOL, 6'($urandom_range(NC, 63)), 10'($urandom),
				rand_value(), rand_value());
		else
			send_beat(MODE_NONE, 6'($urandom), 10'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// Output side stalls at random.
	initial begin
		int g;
		out_ch.ready <= 1'b0;
		forever begin
			g = gap_len();
			if (g > 0) begin
				out_ch.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		no_gaps = 1'b0;
		sample_idx = 0;
		idle_cycles = 0;
		beats_sent = 0;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.mode <= MODE_NONE;
		in_ch.carrier <= '0;
		in_ch.sample_pos <= '0;
		in_ch.value_re <= '0;
		in_ch.value_im <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Ignored beats: spare mode and writes outside the table.
		send_beat(MODE_NONE, 6'h3f, 10'h3ff, 16'hffff, 16'hffff);
		send_beat(MODE_SYMBOL, 6'(NC), 10'h000, 16'h7fff, 16'h8000);
		send_beat(MODE_SYMBOL, 6'h3f, 10'h3ff, 16'h8000, 16'h7fff);
		send_beat(MODE_COEFF, 6'h3f, 10'h000, 16'h7fff, 16'h7fff);
		send_beat(MODE_COEFF, 6'h00, 10'(SL), 16'h8000, 16'h8000);
		send_beat(MODE_COEFF, 6'(NC-1), 10'h3ff, 16'h1234, 16'h4321);

		// All symbols zero gives a zero sum.
		for (int c = 0; c < NC; c++) send_beat(MODE_SYMBOL, 6'(c), 10'h000, 16'h0000, 16'h0000);
		request_sample();

		// Extremes on symbols and coefficients, both signs.
		send_beat(MODE_SYMBOL, 6'd0, 10'h000, 16'h8000, 16'h8000);
		send_beat(MODE_SYMBOL, 6'(NC-1), 10'h000, 16'h7fff, 16'h7fff);
		for (int c = 0; c < NC; c++)
			send_beat(MODE_COEFF, 6'(c), 10'((sample_idx + SL - PL) % SL),
				(c % 2) ? 16'h7fff : 16'h8000, (c % 2) ? 16'h8000 : 16'h7fff);
		request_sample();

		// Fill beats count toward the total, so the loop runs on beats sent.
		for (int i = 0; beats_sent < RANDOM_ITEMS; i++) begin
			if (i % 150 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			random_item();
		end
		no_gaps = 1'b0;
		in_ch.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_cnt == 0 && pending == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* sim.f */
sv/oidft_pkg.sv
sv/oidft_if.sv
sv/oidft_ram.sv
sv/oidft_front.sv
sv/oidft_back.sv
sv/ofdm_idft_prefix_unit_clip.sv
test/oidft_checker.sv
test/testbench.sv
